>>> src/skc_pkg.sv
// shared types, codes and helpers for the sorted key cache
`timescale 1ns / 1ps
`default_nettype none
package skc_pkg;

  localparam int Capacity = 32;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int KeyW     = 32;
  localparam int TallyW   = 17;

  // one stored table entry
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [31:0]     handle;
    logic [31:0]     stamp;
    logic            busy;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [2:0] {
    FN_LOOKUP  = 3'd0,
    FN_RELEASE = 3'd1,
    FN_REL_ALL = 3'd2,
    FN_SETBUSY = 3'd3,
    FN_VISIT   = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    K_HIT      = 4'd0,
    K_INSERTED = 4'd1,
    K_FULL     = 4'd2,
    K_BADKEY   = 4'd3,
    K_NOTFOUND = 4'd4,
    K_RELEASED = 4'd5,
    K_EVICTED  = 4'd6,
    K_VISITED  = 4'd7,
    K_DONE     = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    REG_BALANCE = 2'd0,
    REG_PERIOD  = 2'd1,
    REG_IDLE    = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_S_RD, ST_S_CHK, ST_DECIDE, ST_SH_RD, ST_SH_WR, ST_BAL,
    ST_CNT_RD, ST_CNT_CHK, ST_SW_RD, ST_SW_CHK, ST_SC_RD, ST_SC_CHK,
    ST_DEL_RD, ST_DEL_WR, ST_EMIT
  } state_t;

  // idle test with a wrapping tick counter
  function automatic logic evict_ok(entry_t e, logic [31:0] now, logic [30:0] max_idle);
    logic [31:0] age;
    age = now - e.stamp;
    return !e.busy && (age >= {1'b0, max_idle});
  endfunction

endpackage
`default_nettype wire

>>> src/skc_ram.sv
// simple dual port memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module skc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire                     rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/sorted_key_cache_with_idle_sweep.sv
// Sorted key cache with idle sweep: usage notes
// Input channel s_*: one operation per transfer; tuser carries the function
// code, tdata the key, handle, current tick and busy request.
// Output channel m_*: one or more results per operation; tlast marks the
// final one. tuser carries the result kind.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 balance count, 1 check period, 2 max idle) at the clock edge.
// Timing: the table lives in one memory with one read and one write a cycle
// and registered read data; a table walk reads each entry and then checks
// it, and every result it sends passes through the emit state.
// A lookup, key release or set busy walks the table up to its key's position
// before its result; an insert then moves the entries above the position up,
// and a release moves the entries after it down once its result is out.
// Release all and visit walk every entry. A sweep adds a counting pass and
// a compacting pass, with one result per eviction.
// One operation is in work at a time; s_tready is high only between them.
// Results go out through an output register; a stalled receiver holds the
// walk at the next result, and nothing is lost.
// Reset empties the table, clears the access tally and loads the default
// register values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_cache_with_idle_sweep (
  input  wire          clk,
  input  wire          rst,
  // tdata: key[31:0], handle[63:32], now[95:64], busy_req[96], zero fill
  input  wire  [103:0] s_tdata,
  // tuser: func[2:0]
  input  wire  [2:0]   s_tuser,
  input  wire          s_tvalid,
  output logic         s_tready,
  // tdata: out_key[31:0], out_handle[63:32], position[68:64],
  // entry_count[74:69], zero fill
  output logic [79:0]  m_tdata,
  // tuser: kind[3:0]
  output logic [3:0]   m_tuser,
  output logic         m_tlast,
  output logic         m_tvalid,
  input  wire          m_tready,
  input  wire          cfg_wr_en,
  input  wire  [1:0]   cfg_index,
  input  wire  [30:0]  cfg_data
);
  import skc_pkg::*;

  state_t state, state_next, ret, ret_next;
  logic [CntW-1:0] idx, idx_next, jdx, jdx_next, kept, kept_next;
  logic [CntW-1:0] ev, ev_next, used, used_next, fin, fin_next;
  logic [TallyW-1:0] tally, tally_next, tally_inc;
  logic found, found_next;
  entry_t ent, ent_next;
  func_t op, op_next;
  logic [KeyW-1:0] in_key, in_key_next;
  logic [31:0] in_handle, in_handle_next, in_now, in_now_next;
  logic in_busy, in_busy_next;
  kind_t res_kind, res_kind_next;
  logic [KeyW-1:0] res_key, res_key_next;
  logic [31:0] res_handle, res_handle_next;
  logic [IdxW-1:0] res_pos, res_pos_next;
  logic res_last, res_last_next;
  logic [5:0] balance_count;
  logic [15:0] check_period;
  logic [30:0] max_idle;

  logic ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, rd_ent;
  logic [EntryW-1:0] rd_raw;
  logic slot_free, rd_evict, sweep_due, above_bal;
  logic [CntW-1:0] jdx_inc, jdx_dec;

  skc_ram #(.WIDTH(EntryW), .DEPTH(Capacity)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (rd_raw)
  );

  // shared terms
  assign rd_ent    = entry_t'(rd_raw);
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign rd_evict  = evict_ok(rd_ent, in_now, max_idle);
  assign tally_inc = (&tally) ? tally : tally + 1'b1;
  assign above_bal = (6'(used) > balance_count);
  assign sweep_due = above_bal && (tally_inc > TallyW'(check_period));
  assign jdx_inc   = jdx + 1'b1;
  assign jdx_dec   = jdx - 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            FN_LOOKUP:  state_next = (s_tdata[31:0] == '0) ? ST_EMIT : ST_S_RD;
            FN_RELEASE, FN_SETBUSY: state_next = ST_S_RD;
            FN_REL_ALL, FN_VISIT:   state_next = ST_SC_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_S_RD:    state_next = (idx == used) ? ST_DECIDE : ST_S_CHK;
      ST_S_CHK:   state_next = (rd_ent.key < in_key) ? ST_S_RD : ST_DECIDE;
      ST_DECIDE: begin
        if (op == FN_LOOKUP && found) begin
          state_next = ST_BAL;
        end else if (op == FN_LOOKUP && used != CntW'(Capacity)) begin
          state_next = ST_SH_RD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SH_RD:   state_next = (jdx == idx) ? ST_BAL : ST_SH_WR;
      ST_SH_WR:   state_next = ST_SH_RD;
      ST_BAL:     state_next = sweep_due ? ST_CNT_RD : ST_EMIT;
      ST_CNT_RD:  state_next = (jdx == used) ? ST_EMIT : ST_CNT_CHK;
      ST_CNT_CHK: state_next = ST_CNT_RD;
      ST_SW_RD:   state_next = (jdx == used) ? ST_IDLE : ST_SW_CHK;
      ST_SW_CHK:  state_next = rd_evict ? ST_EMIT : ST_SW_RD;
      ST_SC_RD:   state_next = (jdx == used) ? ST_EMIT : ST_SC_CHK;
      ST_SC_CHK: begin
        state_next = (op == FN_REL_ALL || rd_ent.handle != '0) ? ST_EMIT : ST_SC_RD;
      end
      ST_DEL_RD:  state_next = (jdx_inc >= used) ? ST_IDLE : ST_DEL_WR;
      ST_DEL_WR:  state_next = ST_DEL_RD;
      ST_EMIT:    state_next = slot_free ? ret : ST_EMIT;
      default:    state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ret_next = ret;          idx_next = idx;        jdx_next = jdx;
    kept_next = kept;        ev_next = ev;          used_next = used;
    fin_next = fin;          tally_next = tally;    found_next = found;
    ent_next = ent;          op_next = op;          in_key_next = in_key;
    in_handle_next = in_handle; in_now_next = in_now; in_busy_next = in_busy;
    res_kind_next = res_kind; res_key_next = res_key; res_handle_next = res_handle;
    res_pos_next = res_pos;  res_last_next = res_last;
    ram_we = 1'b0; ram_waddr = idx[IdxW-1:0]; ram_wdata = ent;
    ram_re = 1'b0; ram_raddr = jdx[IdxW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          op_next = func_t'(s_tuser);
          in_key_next = s_tdata[31:0];
          in_handle_next = s_tdata[63:32];
          in_now_next = s_tdata[95:64];
          in_busy_next = s_tdata[96];
          idx_next = '0;
          jdx_next = '0;
          fin_next = (s_tuser == FN_REL_ALL) ? '0 : used;
          res_kind_next = K_BADKEY;
          res_key_next = '0;
          res_handle_next = '0;
          res_pos_next = '0;
          res_last_next = 1'b1;
          ret_next = ST_IDLE;
        end
      end
      ST_S_RD: begin
        if (idx == used) begin
          found_next = 1'b0;
        end else begin
          ram_re = 1'b1;
          ram_raddr = idx[IdxW-1:0];
        end
      end
      ST_S_CHK: begin
        ent_next = rd_ent;
        if (rd_ent.key < in_key) begin
          idx_next = idx + 1'b1;
        end else begin
          found_next = (rd_ent.key == in_key);
        end
      end
      ST_DECIDE: begin
        res_key_next = in_key;
        res_last_next = 1'b1;
        ret_next = ST_IDLE;
        if (found) begin
          res_kind_next = (op == FN_RELEASE) ? K_RELEASED : K_HIT;
          res_handle_next = ent.handle;
          res_pos_next = idx[IdxW-1:0];
          if (op == FN_LOOKUP) begin
            ram_we = 1'b1;
            ram_wdata = '{key: ent.key, handle: ent.handle, stamp: in_now, busy: ent.busy};
          end else if (op == FN_SETBUSY) begin
            ram_we = 1'b1;
            ram_wdata = '{key: ent.key, handle: ent.handle, stamp: ent.stamp, busy: in_busy};
          end else begin
            fin_next = used - 1'b1;
            jdx_next = idx;
            ret_next = ST_DEL_RD;
          end
        end else if (op == FN_LOOKUP) begin
          if (used == CntW'(Capacity)) begin
            res_kind_next = K_FULL;
          end else begin
            res_kind_next = K_INSERTED;
            res_handle_next = in_handle;
            res_pos_next = idx[IdxW-1:0];
            jdx_next = used;
          end
        end else begin
          res_kind_next = K_NOTFOUND;
        end
      end
      // open a gap at the insert position, moving from the top down
      ST_SH_RD: begin
        if (jdx == idx) begin
          ram_we = 1'b1;
          ram_wdata = '{key: in_key, handle: in_handle, stamp: in_now, busy: 1'b0};
          used_next = used + 1'b1;
        end else begin
          ram_re = 1'b1;
          ram_raddr = jdx_dec[IdxW-1:0];
        end
      end
      ST_SH_WR: begin
        ram_we = 1'b1;
        ram_waddr = jdx[IdxW-1:0];
        ram_wdata = rd_ent;
        jdx_next = jdx_dec;
      end
      ST_BAL: begin
        if (above_bal) begin
          tally_next = tally_inc;
        end
        fin_next = used;
        jdx_next = '0;
        ev_next = '0;
      end
      // first sweep pass only counts evictions
      ST_CNT_RD: begin
        if (jdx == used) begin
          tally_next = '0;
          fin_next = used - ev;
          res_last_next = (ev == '0);
          ret_next = (ev == '0) ? ST_IDLE : ST_SW_RD;
          jdx_next = '0;
          kept_next = '0;
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_CNT_CHK: begin
        if (rd_evict) begin
          ev_next = ev + 1'b1;
        end
        jdx_next = jdx_inc;
      end
      ST_SW_RD: begin
        if (jdx == used) begin
          used_next = kept;
        end else begin
          ram_re = 1'b1;
        end
      end
      // second pass reports evictions and compacts survivors
      ST_SW_CHK: begin
        jdx_next = jdx_inc;
        if (rd_evict) begin
          res_kind_next = K_EVICTED;
          res_key_next = rd_ent.key;
          res_handle_next = rd_ent.handle;
          res_pos_next = jdx[IdxW-1:0];
          res_last_next = (ev == CntW'(1));
          ev_next = ev - 1'b1;
          ret_next = ST_SW_RD;
        end else begin
          ram_we = 1'b1;
          ram_waddr = kept[IdxW-1:0];
          ram_wdata = rd_ent;
          kept_next = kept + 1'b1;
        end
      end
      ST_SC_RD: begin
        if (jdx == used) begin
          res_kind_next = K_DONE;
          res_key_next = '0;
          res_handle_next = '0;
          res_pos_next = '0;
          res_last_next = 1'b1;
          ret_next = ST_IDLE;
          if (op == FN_REL_ALL) begin
            used_next = '0;
            tally_next = '0;
          end
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_SC_CHK: begin
        jdx_next = jdx_inc;
        res_kind_next = (op == FN_REL_ALL) ? K_RELEASED : K_VISITED;
        res_key_next = rd_ent.key;
        res_handle_next = rd_ent.handle;
        res_pos_next = jdx[IdxW-1:0];
        res_last_next = 1'b0;
        ret_next = ST_SC_RD;
      end
      // close the gap left by a released key
      ST_DEL_RD: begin
        if (jdx_inc >= used) begin
          used_next = used - 1'b1;
        end else begin
          ram_re = 1'b1;
          ram_raddr = jdx_inc[IdxW-1:0];
        end
      end
      ST_DEL_WR: begin
        ram_we = 1'b1;
        ram_waddr = jdx[IdxW-1:0];
        ram_wdata = rd_ent;
        jdx_next = jdx_inc;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= ST_IDLE;
      used <= '0;
      tally <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      used <= used_next;
      tally <= tally_next;
      if (state == ST_EMIT && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      balance_count <= 6'd16;
      check_period <= 16'd64;
      max_idle <= 31'd100000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BALANCE: balance_count <= cfg_data[5:0];
        REG_PERIOD:  check_period <= cfg_data[15:0];
        REG_IDLE:    max_idle <= cfg_data;
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    idx <= idx_next;       jdx <= jdx_next;       kept <= kept_next;
    ev <= ev_next;         fin <= fin_next;       found <= found_next;
    ent <= ent_next;       op <= op_next;         in_key <= in_key_next;
    in_handle <= in_handle_next; in_now <= in_now_next; in_busy <= in_busy_next;
    res_kind <= res_kind_next; res_key <= res_key_next;
    res_handle <= res_handle_next; res_pos <= res_pos_next;
    res_last <= res_last_next;
    if (state == ST_EMIT && slot_free) begin
      m_tuser <= res_kind;
      m_tdata <= {5'd0, fin, res_pos, res_handle, res_key};
      m_tlast <= res_last;
    end
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CntW'(Capacity)) else $error("entry count above capacity");
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !ram_we) else $error("memory write while idle");
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_SW_CHK |-> kept <= jdx) else $error("compaction overtakes scan");
  a_evict_budget: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SW_CHK && rd_evict) |-> ev != '0) else $error("extra eviction");
`endif

endmodule
`default_nettype wire

>>> tb/sorted_key_cache_with_idle_sweep_tb.sv
// testbench for the sorted key cache: random and directed operations checked against a model
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_cache_with_idle_sweep_tb;
  import skc_pkg::*;

  // one expected or observed result
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] key;
    logic [31:0] handle;
    logic [4:0]  pos;
    logic [5:0]  cnt;
    logic        last;
  } cache_result_t;

  // result tracker with its own copy of the cache table
  class cache_scoreboard;
    logic [31:0] keys[Capacity];
    logic [31:0] handles[Capacity];
    logic [31:0] stamps[Capacity];
    bit          busy[Capacity];
    int          used;
    int          tally;
    int          bal_cnt;
    int          period;
    logic [30:0] idle_max;
    cache_result_t pending[$];
    cache_result_t fresh[$];
    int          errors;

    function new();
      used = 0;
      tally = 0;
      bal_cnt = 16;
      period = 64;
      idle_max = 31'd100000;
      errors = 0;
      foreach (busy[i]) busy[i] = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [30:0] val);
      case (idx)
        REG_BALANCE: bal_cnt = val[5:0];
        REG_PERIOD: period = val[15:0];
        default: idle_max = val;
      endcase
    endfunction

    function void emit(kind_t k, logic [31:0] key, logic [31:0] h, int p);
      cache_result_t r;
      r.kind = k;
      r.key = key;
      r.handle = h;
      r.pos = p[4:0];
      r.cnt = 0;
      r.last = 0;
      fresh.push_back(r);
    endfunction

    function int lower_index(logic [31:0] k);
      int i;
      i = 0;
      while (i < used && keys[i] < k) i++;
      return i;
    endfunction

    function int locate(logic [31:0] k);
      int i;
      i = lower_index(k);
      if (i < used && keys[i] == k) return i;
      return -1;
    endfunction

    // drop idle entries and compact
    function void idle_sweep(logic [31:0] now);
      int kept;
      logic [31:0] age;
      kept = 0;
      tally = 0;
      for (int i = 0; i < used; i++) begin
        age = now - stamps[i];
        if (!busy[i] && age >= {1'b0, idle_max}) begin
          emit(K_EVICTED, keys[i], handles[i], i);
          continue;
        end
        keys[kept] = keys[i];
        handles[kept] = handles[i];
        stamps[kept] = stamps[i];
        busy[kept] = busy[i];
        kept++;
      end
      for (int i = kept; i < used; i++) busy[i] = 0;
      used = kept;
    endfunction

    function void count_access(logic [31:0] now);
      if (used > bal_cnt) begin
        if (tally < 131071) tally++;
        if (tally > period) idle_sweep(now);
      end
    endfunction

    // apply one accepted operation and queue its results
    function void note_op(logic [2:0] fn, logic [31:0] key, logic [31:0] h,
                          logic [31:0] now, bit bz);
      int p;
      fresh.delete();
      case (fn)
        FN_LOOKUP: begin
          if (key == 0) emit(K_BADKEY, 0, 0, 0);
          else begin
            p = locate(key);
            if (p >= 0) begin
              stamps[p] = now;
              emit(K_HIT, key, handles[p], p);
              count_access(now);
            end else if (used >= Capacity) emit(K_FULL, key, 0, 0);
            else begin
              p = lower_index(key);
              for (int j = used; j > p; j--) begin
                keys[j] = keys[j-1];
                handles[j] = handles[j-1];
                stamps[j] = stamps[j-1];
                busy[j] = busy[j-1];
              end
              keys[p] = key;
              handles[p] = h;
              stamps[p] = now;
              busy[p] = 0;
              used++;
              emit(K_INSERTED, key, h, p);
              count_access(now);
            end
          end
        end
        FN_RELEASE: begin
          p = locate(key);
          if (p < 0) emit(K_NOTFOUND, key, 0, 0);
          else begin
            emit(K_RELEASED, key, handles[p], p);
            for (int i = p; i + 1 < used; i++) begin
              keys[i] = keys[i+1];
              handles[i] = handles[i+1];
              stamps[i] = stamps[i+1];
              busy[i] = busy[i+1];
            end
            used--;
            busy[used] = 0;
          end
        end
        FN_REL_ALL: begin
          for (int i = 0; i < used; i++) emit(K_RELEASED, keys[i], handles[i], i);
          emit(K_DONE, 0, 0, 0);
          used = 0;
          tally = 0;
          foreach (busy[i]) busy[i] = 0;
        end
        FN_SETBUSY: begin
          p = locate(key);
          if (p < 0) emit(K_NOTFOUND, key, 0, 0);
          else begin
            busy[p] = bz;
            emit(K_HIT, key, handles[p], p);
          end
        end
        FN_VISIT: begin
          for (int i = 0; i < used; i++)
            if (handles[i] != 0) emit(K_VISITED, keys[i], handles[i], i);
          emit(K_DONE, 0, 0, 0);
        end
        default: ;
      endcase
      foreach (fresh[i]) begin
        fresh[i].cnt = used[5:0];
        fresh[i].last = (i == fresh.size() - 1);
        pending.push_back(fresh[i]);
      end
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp kind %0d key %h h %h pos %0d cnt %0d last %b, ",
                   exp.kind, exp.key, exp.handle, exp.pos, exp.cnt, exp.last,
                   "got kind %0d key %h h %h pos %0d cnt %0d last %b",
                   got.kind, got.key, got.handle, got.pos, got.cnt, got.last);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic [103:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         s_tvalid = 0;
  wire          s_tready;
  wire  [79:0]  m_tdata;
  wire  [3:0]   m_tuser;
  wire          m_tlast;
  wire          m_tvalid;
  logic         m_tready = 0;
  logic         cfg_wr_en = 0;
  logic [1:0]   cfg_index = '0;
  logic [30:0]  cfg_data = '0;

  cache_scoreboard sb;
  bit          calm;
  longint      cycles = 0;
  logic [31:0] key_pool[8];
  logic [31:0] tick = 0;

  sorted_key_cache_with_idle_sweep dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver with random stalls, checks each result transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result('{m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[68:64],
                        m_tdata[74:69], m_tlast});
    m_tready <= calm || ($urandom_range(99) >= 34);
  end

  task automatic send_op(logic [2:0] fn, logic [31:0] key, logic [31:0] h,
                         logic [31:0] now, bit bz);
    while (!calm && $urandom_range(99) < 34) @(posedge clk);
    s_tvalid <= 1;
    s_tuser <= fn;
    s_tdata <= {7'd0, bz, now, h, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_op(fn, key, h, now, bz);
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (sb.pending.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [30:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(7)];
  endfunction

  task automatic random_ops(int n, int tick_step);
    int r;
    for (int i = 0; i < n; i++) begin
      tick = tick + $urandom_range(tick_step);
      r = $urandom_range(99);
      if (r < 55) send_op(FN_LOOKUP, pick_key(), $urandom_range(3) == 0 ? 0 : $urandom,
                          tick, 0);
      else if (r < 70) send_op(FN_RELEASE, pick_key(), $urandom, tick, 0);
      else if (r < 82) send_op(FN_SETBUSY, pick_key(), $urandom, tick, $urandom_range(1));
      else if (r < 90) send_op(FN_VISIT, $urandom, $urandom, tick, 0);
      else if (r < 93) send_op(FN_REL_ALL, $urandom, $urandom, tick, 0);
      else if (r < 96) send_op(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, 1);
      else send_op(FN_LOOKUP, 0, $urandom, tick, $urandom_range(1));
    end
  endtask

  initial begin
    sb = new();
    calm = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom_range(40) + 1;
    key_pool[7] = 32'hFFFF_FFFF;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes and every operation
    send_op(FN_LOOKUP, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_op(FN_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1);
    send_op(FN_LOOKUP, 1, 0, 32'hFFFF_FFF0, 0);
    send_op(FN_LOOKUP, 32'h8000_0000, 32'h1234_5678, 10, 0);
    send_op(FN_LOOKUP, 1, 5, 20, 0);
    send_op(FN_SETBUSY, 1, 0, 21, 1);
    send_op(FN_SETBUSY, 7, 0, 21, 1);
    send_op(FN_VISIT, 0, 0, 22, 0);
    send_op(FN_RELEASE, 32'h8000_0000, 0, 23, 0);
    send_op(FN_RELEASE, 99, 0, 23, 0);
    send_op(3'd5, 1, 1, 1, 1);
    send_op(3'd7, 1, 1, 1, 1);
    send_op(FN_REL_ALL, 0, 0, 24, 0);
    send_op(FN_REL_ALL, 0, 0, 24, 0);

    // fill to capacity, then overflow, sweep with max_idle zero
    drain();
    write_cfg(REG_BALANCE, 0);
    write_cfg(REG_PERIOD, 40);
    write_cfg(REG_IDLE, 0);
    for (int i = 0; i < Capacity; i++) send_op(FN_LOOKUP, 100 + 3 * i, i, 30, 0);
    send_op(FN_LOOKUP, 5, 5, 31, 0);
    send_op(FN_SETBUSY, 103, 0, 31, 1);
    drain();
    write_cfg(REG_PERIOD, 0);
    send_op(FN_LOOKUP, 100, 0, 40, 0);
    send_op(FN_REL_ALL, 0, 0, 41, 0);

    // random phases over several register settings
    drain();
    write_cfg(REG_BALANCE, 2);
    write_cfg(REG_PERIOD, 3);
    write_cfg(REG_IDLE, 50);
    random_ops(40, 20);
    calm = 1;
    random_ops(20, 20);
    calm = 0;
    drain();
    write_cfg(REG_BALANCE, 32);
    write_cfg(REG_PERIOD, 65535);
    write_cfg(REG_IDLE, 31'h7FFF_FFFF);
    random_ops(30, 1000);
    drain();
    write_cfg(REG_BALANCE, 4);
    write_cfg(REG_PERIOD, 1);
    write_cfg(REG_IDLE, 31'h4000_0000);
    tick = 32'hFFFF_FF00;
    random_ops(30, 32'h2000_0000);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
src/skc_pkg.sv
src/skc_ram.sv
src/sorted_key_cache_with_idle_sweep.sv
tb/sorted_key_cache_with_idle_sweep_tb.sv
